[design/mjs_pkg.sv]
`timescale 1ns / 1ps

package mjs_pkg;

    localparam int MAX_CORES_DEF   = 8;
    localparam int QUEUE_DEPTH_DEF = 64;
    localparam int SCHEME_W        = 3;
    localparam int CORES_W         = 4;
    localparam int CFG_IDX_W       = 1;
    localparam int CFG_DATA_W      = 4;
    localparam logic [47:0] SUM_MAX = 48'hFFFF_FFFF_FFFF;
    localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SCHEME = 1'b0,
        CFG_CORES  = 1'b1
    } cfg_idx_t;

    typedef enum logic [1:0] {
        REQ_ARRIVE = 2'd0,
        REQ_FINISH = 2'd1,
        REQ_EXPIRE = 2'd2,
        REQ_NONE   = 2'd3
    } req_t;

    typedef enum logic [2:0] {
        SCH_FCFS = 3'd0,
        SCH_SJF  = 3'd1,
        SCH_PSJF = 3'd2,
        SCH_PRI  = 3'd3,
        SCH_PPRI = 3'd4,
        SCH_RR   = 3'd5,
        SCH_X6   = 3'd6,
        SCH_X7   = 3'd7
    } sched_mode_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHARGE,
        ST_SCAN,
        ST_DECIDE,
        ST_FIND_RD,
        ST_FIND_CMP,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_PUT,
        ST_POP_RD,
        ST_POP_SH,
        ST_POP_WR,
        ST_LOAD,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [31:0] event_time;
        logic [15:0] job_tag;
        logic [31:0] run_length;
        logic [7:0]  job_priority;
        logic [2:0]  core_index;
    } in_beat_t;

    typedef struct packed {
        logic        placed;
        logic [2:0]  placed_core;
        logic [15:0] placed_job;
        logic        queue_overflow;
        logic [47:0] wait_sum;
        logic [47:0] turnaround_sum;
        logic [47:0] response_sum;
        logic [31:0] finished_count;
        logic [31:0] response_count;
    } out_beat_t;

    typedef struct packed {
        logic [15:0] id;
        logic [7:0]  prio;
        logic [31:0] arrival;
        logic [31:0] remaining;
        logic [31:0] total;
        logic        started;
    } job_t;

    function automatic logic [31:0] job_key(input logic [SCHEME_W-1:0] s, input job_t j);
        logic [31:0] k;
        unique case (sched_mode_t'(s))
            SCH_SJF:           k = j.total;
            SCH_PSJF:          k = j.remaining;
            SCH_PRI, SCH_PPRI: k = {24'd0, j.prio};
            SCH_RR:            k = 32'd0;
            default:           k = j.arrival;
        endcase
        return k;
    endfunction

    function automatic logic [47:0] sat_add(input logic [47:0] a, input logic [31:0] v);
        logic [48:0] s;
        s = {1'b0, a} + {17'd0, v};
        return s[48] ? SUM_MAX : s[47:0];
    endfunction

endpackage

[design/multicore_job_scheduler_core.sv]
`timescale 1ns / 1ps

// channel | valid     | ready     | payload
// in      | in_valid  | in_ready  | in_beat  (mjs_pkg::in_beat_t)
// out     | out_valid | out_ready | out_beat (mjs_pkg::out_beat_t)
// cfg     | cfg_valid | cfg_ready | cfg_index, cfg_data
// one event walks the cores, then searches or shifts queue entries one at a time
// through the single-port queue memory. in_ready is high only in idle; the result
// waits in an output register until taken. reset clears cores, counts and sums;
// the queue needs no clearing since entries past the count are never read.

module multicore_job_scheduler_core #(
    parameter int MAX_CORES   = mjs_pkg::MAX_CORES_DEF,
    parameter int QUEUE_DEPTH = mjs_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  mjs_pkg::in_beat_t                  in_beat,
    output logic                               out_valid,
    input  logic                               out_ready,
    output mjs_pkg::out_beat_t                 out_beat,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [mjs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mjs_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int CW = (MAX_CORES > 1) ? $clog2(MAX_CORES) : 1;
    localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int NW = $clog2(MAX_CORES + 1);
    localparam int RW = $clog2(QUEUE_DEPTH + 1);

    mjs_pkg::state_t state_reg, state_next;

    logic [mjs_pkg::SCHEME_W-1:0] scheme_reg;
    logic [mjs_pkg::CORES_W-1:0]  cores_reg;

    logic [MAX_CORES-1:0] busy_reg;
    mjs_pkg::job_t        core_job_reg [MAX_CORES];
    logic [31:0]          core_last_reg [MAX_CORES];

    mjs_pkg::job_t ready_mem [QUEUE_DEPTH];
    mjs_pkg::job_t rd_reg;
    logic [RW-1:0] ready_count_reg;

    mjs_pkg::in_beat_t ev_reg;
    logic [NW-1:0]     n_reg;
    logic [NW-1:0]     ci_reg;        // core walk index
    logic              tgt_ok_reg;
    logic [CW-1:0]     tgt_reg;
    logic              best_ok_reg;
    logic [CW-1:0]     best_reg;
    logic [31:0]       best_key_reg;
    mjs_pkg::job_t     ins_reg;       // job to be inserted
    mjs_pkg::job_t     ld_reg;        // job to be loaded on core
    logic [RW-1:0]     pos_reg;       // search/shift position
    logic [RW-1:0]     ins_pos_reg;
    logic              pop_then_ins_reg;
    logic              do_load_reg;
    logic              expire_reg;

    logic [47:0] wait_reg, turn_reg, resp_reg;
    logic [31:0] fin_reg, rcnt_reg;

    mjs_pkg::out_beat_t out_reg;
    logic               out_valid_reg;

    // active core count, clamped
    logic [NW-1:0] n_act;
    always_comb
    begin
        if (cores_reg == '0)
            n_act = NW'(1);
        else if (32'(cores_reg) > MAX_CORES)
            n_act = NW'(MAX_CORES);
        else
            n_act = NW'(cores_reg);
    end

    logic [CW-1:0] ci;
    assign ci = ci_reg[CW-1:0];

    mjs_pkg::job_t cur_core;
    assign cur_core = core_job_reg[ci];

    logic        psjf;
    logic [31:0] new_key, cur_key;
    assign psjf    = (mjs_pkg::sched_mode_t'(scheme_reg) == mjs_pkg::SCH_PSJF);
    assign new_key = psjf ? ev_reg.run_length : {24'd0, ev_reg.job_priority};
    assign cur_key = psjf ? cur_core.remaining : {24'd0, cur_core.prio};

    logic [31:0] elapsed;
    assign elapsed = ev_reg.event_time - core_last_reg[ci];

    logic ins_less;
    assign ins_less = mjs_pkg::job_key(scheme_reg, ins_reg) < mjs_pkg::job_key(scheme_reg, rd_reg);

    logic q_full;
    assign q_full = (32'(ready_count_reg) >= QUEUE_DEPTH);

    logic [2:0] ev_core;
    assign ev_core = ev_reg.core_index;

    logic ev_core_ok;
    assign ev_core_ok = (NW'(ev_core) < n_reg) && (32'(ev_core) < MAX_CORES)
                        && busy_reg[ev_core[CW-1:0]];

    assign in_ready  = (state_reg == mjs_pkg::ST_IDLE) && !out_valid_reg;
    assign cfg_ready = (state_reg == mjs_pkg::ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_beat  = out_reg;

    // decide step outputs (combinational)
    typedef struct packed {
        logic          go_find;   // insert ins into queue
        logic          go_pop;    // pop head first
        logic          pop_ins;   // after pop, insert ins (expiry)
        logic          load;
        logic          ovf;
        logic          take;      // core leaves busy
        logic [CW-1:0] core;
    } plan_t;

    plan_t plan;
    mjs_pkg::job_t arr_job;
    always_comb
    begin
        arr_job.id        = ev_reg.job_tag;
        arr_job.prio      = ev_reg.job_priority;
        arr_job.arrival   = ev_reg.event_time;
        arr_job.remaining = ev_reg.run_length;
        arr_job.total     = ev_reg.run_length;
        arr_job.started   = 1'b0;
    end

    always_comb
    begin
        plan = '0;
        plan.core = ev_core[CW-1:0];
        priority if (mjs_pkg::req_t'(ev_reg.req_type) == mjs_pkg::REQ_ARRIVE)
        begin
            if (tgt_ok_reg)
            begin
                plan.load = 1'b1;
                plan.core = tgt_reg;
            end
            else if (best_ok_reg)
            begin
                if (q_full)
                    plan.ovf = 1'b1;
                else
                begin
                    plan.take    = 1'b1;
                    plan.go_find = 1'b1;
                    plan.load    = 1'b1;
                    plan.core    = best_reg;
                end
            end
            else if (q_full)
                plan.ovf = 1'b1;
            else
                plan.go_find = 1'b1;
        end
        else if (ev_core_ok)
        begin
            plan.take = 1'b1;
            if (mjs_pkg::req_t'(ev_reg.req_type) == mjs_pkg::REQ_FINISH)
            begin
                plan.go_pop = (ready_count_reg != '0);
                plan.load   = plan.go_pop;
            end
            else
            begin
                // expiry: find pos of expired job; if not 0, pop and insert at p-1
                plan.go_find = 1'b1;
                plan.pop_ins = 1'b1;
                plan.load    = 1'b1;
            end
        end
    end

    // where to go once the insert position is known
    mjs_pkg::state_t found_next;
    assign found_next = !pop_then_ins_reg ? mjs_pkg::ST_SHIFT_RD
                        : ((pos_reg != '0) ? mjs_pkg::ST_POP_RD : mjs_pkg::ST_LOAD);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mjs_pkg::ST_IDLE:
                if (in_valid && in_ready)
                    state_next = (mjs_pkg::req_t'(in_beat.req_type) == mjs_pkg::REQ_NONE)
                                 ? mjs_pkg::ST_OUT : mjs_pkg::ST_CHARGE;
            mjs_pkg::ST_CHARGE:
                if (ci_reg + NW'(1) >= n_reg)
                    state_next = (mjs_pkg::req_t'(ev_reg.req_type) == mjs_pkg::REQ_ARRIVE)
                                 ? mjs_pkg::ST_SCAN : mjs_pkg::ST_DECIDE;
            mjs_pkg::ST_SCAN:
                if (ci_reg + NW'(1) >= n_reg)
                    state_next = mjs_pkg::ST_DECIDE;
            mjs_pkg::ST_DECIDE:
                if (plan.go_pop)
                    state_next = mjs_pkg::ST_POP_RD;
                else if (plan.go_find)
                    state_next = mjs_pkg::ST_FIND_RD;
                else
                    state_next = mjs_pkg::ST_LOAD;
            mjs_pkg::ST_FIND_RD:
                state_next = (pos_reg >= ready_count_reg) ? found_next
                                                          : mjs_pkg::ST_FIND_CMP;
            mjs_pkg::ST_FIND_CMP:
                state_next = ins_less ? found_next : mjs_pkg::ST_FIND_RD;
            mjs_pkg::ST_SHIFT_RD:
                state_next = (pos_reg > ins_pos_reg) ? mjs_pkg::ST_SHIFT_WR : mjs_pkg::ST_PUT;
            mjs_pkg::ST_SHIFT_WR:
                state_next = mjs_pkg::ST_SHIFT_RD;
            mjs_pkg::ST_PUT:
                state_next = mjs_pkg::ST_LOAD;
            mjs_pkg::ST_POP_RD:
                state_next = mjs_pkg::ST_POP_SH;
            mjs_pkg::ST_POP_SH:
                if (pos_reg >= ready_count_reg)
                    state_next = expire_reg ? mjs_pkg::ST_SHIFT_RD : mjs_pkg::ST_LOAD;
                else
                    state_next = mjs_pkg::ST_POP_WR;
            mjs_pkg::ST_POP_WR:
                state_next = mjs_pkg::ST_POP_SH;
            mjs_pkg::ST_LOAD:
                state_next = mjs_pkg::ST_OUT;
            mjs_pkg::ST_OUT:
                state_next = mjs_pkg::ST_IDLE;
            default:
                state_next = mjs_pkg::ST_IDLE;
        endcase
    end

    logic [31:0] ta, wt;
    assign ta = ev_reg.event_time - core_job_reg[ev_core[CW-1:0]].arrival;
    assign wt = (ta > core_job_reg[ev_core[CW-1:0]].total)
                ? ta - core_job_reg[ev_core[CW-1:0]].total : 32'd0;

    always_ff @(posedge clk)
    begin
        if (state_reg == mjs_pkg::ST_FIND_RD || state_reg == mjs_pkg::ST_POP_RD)
            rd_reg <= ready_mem[pos_reg[QW-1:0]];
        else if (state_reg == mjs_pkg::ST_SHIFT_RD && pos_reg > ins_pos_reg)
            rd_reg <= ready_mem[QW'(pos_reg - RW'(1))];
        else if (state_reg == mjs_pkg::ST_POP_SH && pos_reg < ready_count_reg)
            rd_reg <= ready_mem[pos_reg[QW-1:0]];

        if (state_reg == mjs_pkg::ST_SHIFT_WR)
            ready_mem[pos_reg[QW-1:0]] <= rd_reg;
        else if (state_reg == mjs_pkg::ST_POP_WR)
            ready_mem[QW'(pos_reg - RW'(1))] <= rd_reg;
        else if (state_reg == mjs_pkg::ST_PUT)
            ready_mem[ins_pos_reg[QW-1:0]] <= ins_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= mjs_pkg::ST_IDLE;
            scheme_reg      <= '0;
            cores_reg       <= mjs_pkg::CORES_W'(1);
            busy_reg        <= '0;
            ready_count_reg <= '0;
            wait_reg        <= '0;
            turn_reg        <= '0;
            resp_reg        <= '0;
            fin_reg         <= '0;
            rcnt_reg        <= '0;
            out_valid_reg   <= 1'b0;
            for (int i = 0; i < MAX_CORES; i++)
                core_job_reg[i].started <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;

            if (cfg_valid && cfg_ready)
            begin
                unique case (mjs_pkg::cfg_idx_t'(cfg_index))
                    mjs_pkg::CFG_SCHEME: scheme_reg <= cfg_data[mjs_pkg::SCHEME_W-1:0];
                    mjs_pkg::CFG_CORES:  cores_reg  <= cfg_data;
                    default: ;
                endcase
            end

            unique case (state_reg)
                mjs_pkg::ST_IDLE:
                    if (in_valid && in_ready)
                    begin
                        ev_reg      <= in_beat;
                        n_reg       <= n_act;
                        ci_reg      <= '0;
                        tgt_ok_reg  <= 1'b0;
                        best_ok_reg <= 1'b0;
                        out_reg.placed         <= 1'b0;
                        out_reg.placed_core    <= '0;
                        out_reg.placed_job     <= '0;
                        out_reg.queue_overflow <= 1'b0;
                    end
                mjs_pkg::ST_CHARGE:
                begin
                    if (busy_reg[ci])
                    begin
                        if (!cur_core.started && core_last_reg[ci] != ev_reg.event_time)
                        begin
                            core_job_reg[ci].started <= 1'b1;
                            resp_reg <= mjs_pkg::sat_add(resp_reg,
                                                         core_last_reg[ci] - cur_core.arrival);
                            if (rcnt_reg != mjs_pkg::CNT_MAX)
                                rcnt_reg <= rcnt_reg + 32'd1;
                        end
                        core_job_reg[ci].remaining <= (elapsed > cur_core.remaining)
                                                      ? 32'd0 : cur_core.remaining - elapsed;
                        core_last_reg[ci] <= ev_reg.event_time;
                    end
                    ci_reg <= (ci_reg + NW'(1) >= n_reg) ? '0 : ci_reg + NW'(1);
                end
                mjs_pkg::ST_SCAN:
                begin
                    if (!busy_reg[ci] && !tgt_ok_reg)
                    begin
                        tgt_ok_reg <= 1'b1;
                        tgt_reg    <= ci;
                    end
                    if ((mjs_pkg::sched_mode_t'(scheme_reg) == mjs_pkg::SCH_PSJF
                         || mjs_pkg::sched_mode_t'(scheme_reg) == mjs_pkg::SCH_PPRI)
                        && new_key < cur_key
                        && (!best_ok_reg || cur_key > best_key_reg
                            || (cur_key == best_key_reg
                                && cur_core.arrival > core_job_reg[best_reg].arrival)))
                    begin
                        best_ok_reg  <= 1'b1;
                        best_reg     <= ci;
                        best_key_reg <= cur_key;
                    end
                    ci_reg <= ci_reg + NW'(1);
                end
                mjs_pkg::ST_DECIDE:
                begin
                    out_reg.queue_overflow <= plan.ovf;
                    do_load_reg      <= plan.load;
                    tgt_reg          <= plan.core;
                    pop_then_ins_reg <= plan.pop_ins;
                    expire_reg       <= plan.pop_ins;
                    // an arrival loads the new job, the others the core job until a pop swaps in the head
                    ld_reg <= (plan.take
                               && mjs_pkg::req_t'(ev_reg.req_type) != mjs_pkg::REQ_ARRIVE)
                              ? core_job_reg[plan.core] : arr_job;
                    if (plan.take)
                    begin
                        busy_reg[plan.core] <= 1'b0;
                        ins_reg <= core_job_reg[plan.core];
                    end
                    else
                        ins_reg <= arr_job;
                    if (plan.take && mjs_pkg::req_t'(ev_reg.req_type) == mjs_pkg::REQ_FINISH)
                    begin
                        wait_reg <= mjs_pkg::sat_add(wait_reg, wt);
                        turn_reg <= mjs_pkg::sat_add(turn_reg, ta);
                        if (fin_reg != mjs_pkg::CNT_MAX)
                            fin_reg <= fin_reg + 32'd1;
                    end
                    pos_reg <= '0;
                end
                mjs_pkg::ST_FIND_RD:
                    if (pos_reg >= ready_count_reg)
                    begin
                        // job sorts after the whole queue
                        ins_pos_reg      <= pos_reg;
                        pop_then_ins_reg <= 1'b0;
                        pos_reg          <= pop_then_ins_reg ? '0 : ready_count_reg;
                    end
                mjs_pkg::ST_FIND_CMP:
                    if (ins_less)
                    begin
                        ins_pos_reg      <= pos_reg;
                        pop_then_ins_reg <= 1'b0;
                        pos_reg          <= pop_then_ins_reg ? '0 : ready_count_reg;
                    end
                    else
                        pos_reg <= pos_reg + RW'(1);
                mjs_pkg::ST_SHIFT_RD: ;
                mjs_pkg::ST_SHIFT_WR:
                    pos_reg <= pos_reg - RW'(1);
                mjs_pkg::ST_PUT:
                    ready_count_reg <= ready_count_reg + RW'(1);
                mjs_pkg::ST_POP_RD:
                begin
                    pos_reg <= RW'(1);
                end
                mjs_pkg::ST_POP_SH:
                begin
                    if (pos_reg == RW'(1))
                        ld_reg <= rd_reg;   // head arrives first
                    if (pos_reg >= ready_count_reg)
                    begin
                        ready_count_reg <= ready_count_reg - RW'(1);
                        if (expire_reg)
                        begin
                            // insert expired job at p-1 after the pop
                            ins_pos_reg <= ins_pos_reg - RW'(1);
                            pos_reg     <= ready_count_reg - RW'(1);
                        end
                    end
                end
                mjs_pkg::ST_POP_WR:
                    pos_reg <= pos_reg + RW'(1);
                mjs_pkg::ST_LOAD:
                begin
                    if (do_load_reg)
                    begin
                        busy_reg[tgt_reg]      <= 1'b1;
                        core_job_reg[tgt_reg]  <= ld_reg;
                        core_last_reg[tgt_reg] <= ev_reg.event_time;
                        out_reg.placed         <= 1'b1;
                        out_reg.placed_core    <= 3'(tgt_reg);
                        out_reg.placed_job     <= ld_reg.id;
                    end
                end
                mjs_pkg::ST_OUT:
                begin
                    out_valid_reg          <= 1'b1;
                    out_reg.wait_sum       <= wait_reg;
                    out_reg.turnaround_sum <= turn_reg;
                    out_reg.response_sum   <= resp_reg;
                    out_reg.finished_count <= fin_reg;
                    out_reg.response_count <= rcnt_reg;
                end
                default: ;
            endcase
        end
    end

endmodule

[design/mjs_checker.sv]
`timescale 1ns / 1ps

module mjs_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input mjs_pkg::out_beat_t out_beat
);

    // one beat in, one beat out: no new input while a result waits
    a_no_accept_while_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input taken while result pending");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_beat))
        else $error("result changed while stalled");

    a_no_place_ovf: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(out_beat.placed && out_beat.queue_overflow))
        else $error("placed and overflow together");

    a_fin_mono: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready |=> !out_valid)
        else $error("result repeated");

endmodule

bind multicore_job_scheduler_core mjs_checker u_mjs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_beat  (out_beat)
);
